// ----- rtl/hbe_pkg.sv -----
// Package for the Huffman bitstream encoder: transaction structs, request codes
// and the queue and packer constants. No dependencies.
package hbe_pkg;

  // Request codes of the input channel
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_ENCODE = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;

  // Widths fixed by the transaction format
  localparam int WORD_W = 32;
  localparam int LEN_W  = 6;
  localparam int ACC_W  = WORD_W + 8;

  // Queue between the front and the back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [7:0]        symbol;
    logic [WORD_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       last_of_run;
  } out_item_t;

  // Work handed from the front to the back
  typedef struct packed {
    logic              is_flush;
    logic [WORD_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } work_t;

endpackage

// ----- rtl/hbe_front.sv -----
// Front of the encoder: accepts transactions, writes and reads the code table
// and pushes encode and flush work into the queue. Depends on hbe_pkg.
module hbe_front #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  hbe_pkg::in_item_t      in_data,
  input  logic [hbe_pkg::Q_CW-1:0] q_count,
  output logic                   push_valid,
  output hbe_pkg::work_t         push_data
);

  localparam int CODE_W = (MAX_CODE_LEN < hbe_pkg::WORD_W) ? MAX_CODE_LEN : hbe_pkg::WORD_W;
  localparam int IDX_W  = $clog2(SYMBOL_COUNT);

  logic [CODE_W-1:0]         code_mem [SYMBOL_COUNT];
  logic [hbe_pkg::LEN_W-1:0] len_mem  [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0]   valid_r;

  logic [CODE_W-1:0]         rd_code_r;
  logic [hbe_pkg::LEN_W-1:0] rd_len_r;
  logic                      rd_hit_r;
  logic                      s1_valid_r, s1_valid_nxt;
  logic                      s1_flush_r, s1_flush_nxt;

  logic                      accept;
  logic                      in_range;
  logic [IDX_W-1:0]          idx;
  logic [hbe_pkg::LEN_W-1:0] len_clamped;
  logic                      wr_en;
  logic                      rd_en;
  logic [hbe_pkg::Q_CW:0]    reserved;

  // Hold off input while the queue could not take the item in flight
  assign reserved = {1'b0, q_count} + {{hbe_pkg::Q_CW{1'b0}}, s1_valid_r};
  assign in_stall = (reserved > (hbe_pkg::Q_CW + 1)'(hbe_pkg::Q_DEPTH - 1));
  assign accept   = in_valid && !in_stall;

  // Classify the transaction
  assign in_range    = ({1'b0, in_data.symbol} < 9'(SYMBOL_COUNT));
  assign idx         = in_data.symbol[IDX_W-1:0];
  assign len_clamped = (in_data.code_length > hbe_pkg::LEN_W'(CODE_W)) ?
                       hbe_pkg::LEN_W'(CODE_W) : in_data.code_length;
  assign wr_en = accept && in_range && (in_data.req_type == hbe_pkg::REQ_LOAD);
  assign rd_en = accept && in_range && (in_data.req_type == hbe_pkg::REQ_ENCODE);

  assign s1_valid_nxt = rd_en || (accept && (in_data.req_type == hbe_pkg::REQ_FLUSH));
  assign s1_flush_nxt = (in_data.req_type == hbe_pkg::REQ_FLUSH);

  // Code table: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      code_mem[idx] <= in_data.code_word[CODE_W-1:0];
      len_mem[idx]  <= len_clamped;
    end
    if (rd_en) begin
      rd_code_r <= code_mem[idx];
      rd_len_r  <= len_mem[idx];
      rd_hit_r  <= valid_r[idx];
    end
  end

  // Track loaded entries and the lookup stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      s1_valid_r <= 1'b0;
      s1_flush_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[idx] <= 1'b1;
      end
      s1_valid_r <= s1_valid_nxt;
      s1_flush_r <= s1_flush_nxt;
    end
  end

  // Push the looked-up code; an unloaded entry has no bits
  always_comb begin
    push_valid         = s1_valid_r;
    push_data.is_flush = s1_flush_r;
    push_data.code     = hbe_pkg::WORD_W'(rd_code_r);
    push_data.len      = (rd_hit_r && !s1_flush_r) ? rd_len_r : '0;
  end

endmodule

// ----- rtl/hbe_fifo.sv -----
// Short work queue between the front and the back of the encoder.
// Depends on hbe_pkg.
module hbe_fifo (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push_valid,
  input  hbe_pkg::work_t           push_data,
  input  logic                     pop,
  output logic                     head_valid,
  output hbe_pkg::work_t           head_data,
  output logic [hbe_pkg::Q_CW-1:0] count
);

  hbe_pkg::work_t            entry_r [hbe_pkg::Q_DEPTH];
  logic [hbe_pkg::Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [hbe_pkg::Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [hbe_pkg::Q_CW-1:0]  count_r, count_nxt;
  logic                      do_pop;

  assign head_valid = (count_r != '0);
  assign head_data  = entry_r[rd_ptr_r];
  assign count      = count_r;
  assign do_pop     = pop && head_valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push_valid ? wr_ptr_r + hbe_pkg::Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + hbe_pkg::Q_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + hbe_pkg::Q_CW'(push_valid) - hbe_pkg::Q_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed work
  always_ff @(posedge clk) begin
    if (push_valid) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/hbe_back.sv -----
// Back of the encoder: packs code bits MSB first and sends each full byte (and
// on flush a padded byte) through an output register. Depends on hbe_pkg.
module hbe_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  hbe_pkg::work_t     head_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output hbe_pkg::out_item_t out_data
);

  logic [hbe_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [hbe_pkg::LEN_W-1:0]  cnt_r, cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  hbe_pkg::out_item_t         out_data_r, out_data_nxt;

  logic                        out_free;
  logic                        pop_enc;
  logic                        pop_fl;
  logic [hbe_pkg::WORD_W-1:0]  aligned;
  logic [hbe_pkg::ACC_W-1:0]   placed;
  logic [hbe_pkg::ACC_W-1:0]   view_acc;
  logic [hbe_pkg::LEN_W-1:0]   view_cnt;

  assign out_free = !out_valid_r || !out_stall;

  // Take new work only once fewer than eight bits wait
  assign pop     = head_valid && (cnt_r < 6'd8) && (!head_data.is_flush || out_free);
  assign pop_enc = pop && !head_data.is_flush;
  assign pop_fl  = pop && head_data.is_flush;

  // Left-align the code and place it behind the pending bits
  assign aligned = head_data.code << (6'd32 - head_data.len);
  assign placed  = {aligned, 8'b0} >> cnt_r[2:0];

  always_comb begin
    view_acc      = pop_enc ? (acc_r | placed) : acc_r;
    view_cnt      = pop_enc ? (cnt_r + head_data.len) : cnt_r;
    acc_nxt       = view_acc;
    cnt_nxt       = view_cnt;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (pop_fl) begin
      // Drop the packer contents, sending a padded byte if any bits wait
      acc_nxt = '0;
      cnt_nxt = '0;
      if (cnt_r != '0) begin
        out_valid_nxt            = 1'b1;
        out_data_nxt.packed_byte = acc_r[hbe_pkg::ACC_W-1 -: 8];
        out_data_nxt.last_of_run = 1'b1;
      end
    end else if ((view_cnt >= 6'd8) && out_free) begin
      // Send the top byte and shift the rest up
      out_valid_nxt            = 1'b1;
      out_data_nxt.packed_byte = view_acc[hbe_pkg::ACC_W-1 -: 8];
      out_data_nxt.last_of_run = (view_cnt < 6'd16);
      acc_nxt                  = view_acc << 8;
      cnt_nxt                  = view_cnt - 6'd8;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/huffman_bitstream_encoder.sv -----
// Huffman bitstream encoder: toward the first byte of an encode transaction,
// the table read is registered at the accepting edge, the work is then written
// to the queue, then the packer sends the byte into the output register.
// Throughput: one input transaction per cycle while in_stall is low; the packer
// sends one byte per cycle while out_stall is low, and the queue absorbs input
// while a multi-byte item holds the back. Reset clears the packer, the queue and the table valid bits.
module huffman_bitstream_encoder #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hbe_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hbe_pkg::out_item_t out_data
);

  logic                     push_valid;
  hbe_pkg::work_t           push_data;
  logic                     pop;
  logic                     head_valid;
  hbe_pkg::work_t           head_data;
  logic [hbe_pkg::Q_CW-1:0] q_count;

  // Accept, classify and look up
  hbe_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_count    (q_count),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  // Decouple lookup from packing
  hbe_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data),
    .count      (q_count)
  );

  // Pack bits and send bytes
  hbe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
